FILE: rtl/ccls_pkg.sv
// shared types, constants and calendar helper functions for the calendar counter
package ccls_pkg;

    // field widths
    localparam int WDAY_W  = 3;
    localparam int DATE_W  = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int DAYS_W  = 9;
    localparam int ACT_W   = 2;

    localparam logic [WDAY_W-1:0]  WDAY_RESET  = WDAY_W'(1);
    localparam logic [DATE_W-1:0]  DATE_RESET  = DATE_W'(1);
    localparam logic [MONTH_W-1:0] MONTH_RESET = MONTH_W'(1);
    localparam logic [YEAR_W-1:0]  YEAR_RESET  = YEAR_W'(2000);

    localparam logic [WDAY_W-1:0]  SUNDAY    = WDAY_W'(7);
    localparam logic [MONTH_W-1:0] DECEMBER  = MONTH_W'(12);
    localparam logic [MONTH_W-1:0] FEBRUARY  = MONTH_W'(2);

    // divisibility by 25 over a 16-bit year: multiply by the inverse of 25 mod 2^16,
    // the value is a multiple of 25 exactly when the product is at most 65535 / 25
    localparam logic [YEAR_W-1:0] INV25     = 16'd23593;
    localparam logic [YEAR_W-1:0] DIV25_MAX = 16'd2621;

    typedef enum logic [ACT_W-1:0] {
        ACT_TICK  = 2'd0,
        ACT_SET   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_NONE  = 2'd3
    } act_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEAP_CUR,
        ST_LEAP_NXT,
        ST_EXEC,
        ST_QINIT,
        ST_QWALK,
        ST_SINIT,
        ST_SSTEP,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic leap_cur;
        logic leap_nxt;
        logic exec;
        logic q_init;
        logic q_walk;
        logic s_init;
        logic s_step;
        logic res_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        act_t act;
        logic target_ok;
        logic walk_done;
        logic step_done;
    } dp_sts_t;

    // gregorian leap rule with 4, 100 and 400
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = y * INV25;
        div25 = (prod <= DIV25_MAX);
        return ((y[1:0] == 2'b00) && !div25) || ((y[3:0] == 4'b0000) && div25);
    endfunction

    // days in a month, zero for a month code outside 1..12
    function automatic logic [DATE_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DATE_W-1:0] r;
        case (m) inside
            4'd2:                                  r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:               r = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
            4'd12:                                 r = 5'd31;
            default:                               r = 5'd0;
        endcase
        return r;
    endfunction

    // next month index with wrap after december
    function automatic logic [MONTH_W-1:0] inc_month(input logic [MONTH_W-1:0] m);
        return (m == DECEMBER) ? MONTH_W'(1) : m + MONTH_W'(1);
    endfunction

    // remainder by 7 of a day count: 8 is 1 mod 7, so octal digits add up
    function automatic logic [2:0] mod7(input logic [DAYS_W-1:0] n);
        logic [4:0] s;
        logic [3:0] f;
        s = 5'(n[8:6]) + 5'(n[5:3]) + 5'(n[2:0]);
        f = 4'(s[4:3]) + 4'(s[2:0]);
        return (f >= 4'd7) ? 3'(f - 4'd7) : f[2:0];
    endfunction

endpackage

FILE: rtl/calendar_counter_last_sunday_top.sv
// top level of the calendar counter with last sunday query
//
// Input channel s_*: one command per transfer. s_action selects tick one day,
// load the calendar from the s_set_* fields, or query the last sunday of
// s_target_month (s_force_recalc counts to its next start even inside it).
// Result channel m_*: one transfer per command with the calendar after the
// command and, for a query, the days to the target month and the date of its
// last sunday (both zero otherwise).
// Steps: a tick or a load runs the leap check, the execute step and the
// final step; an unused code or a query with a target outside 1..12 goes
// from the leap check to the final step; a query runs both leap checks, the
// walk setup, the month walk (one month length added per step until the
// target month), the week-step setup, the week steps and the final step.
// One command is in work at a time and the next one is taken in the cycle
// after the result loads. s_ready is high whenever the sequencer is idle,
// also while a result waits.
// A stalled receiver holds the result register; the next command then runs up
// to its final step and waits there. Reset (aresetn low, synchronous) sets
// Monday 1 January 2000 and drops any pending result.
module calendar_counter_last_sunday_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [ccls_pkg::ACT_W-1:0]       s_action,
    input  logic [ccls_pkg::WDAY_W-1:0]      s_set_weekday,
    input  logic [ccls_pkg::DATE_W-1:0]      s_set_day,
    input  logic [ccls_pkg::MONTH_W-1:0]     s_set_month,
    input  logic [ccls_pkg::YEAR_W-1:0]      s_set_year,
    input  logic [ccls_pkg::MONTH_W-1:0]     s_target_month,
    input  logic                             s_force_recalc,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ccls_pkg::WDAY_W-1:0]      m_weekday_now,
    output logic [ccls_pkg::DATE_W-1:0]      m_date_now,
    output logic [ccls_pkg::MONTH_W-1:0]     m_month_now,
    output logic [ccls_pkg::YEAR_W-1:0]      m_year_now,
    output logic [ccls_pkg::DAYS_W-1:0]      m_days_to_target,
    output logic [ccls_pkg::DATE_W-1:0]      m_last_sunday_date
);

    ccls_pkg::dp_cmd_t cmd;
    ccls_pkg::dp_sts_t sts;

    // sequencer
    ccls_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // calendar datapath
    ccls_dp u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .s_action           (s_action),
        .s_set_weekday      (s_set_weekday),
        .s_set_day          (s_set_day),
        .s_set_month        (s_set_month),
        .s_set_year         (s_set_year),
        .s_target_month     (s_target_month),
        .s_force_recalc     (s_force_recalc),
        .m_weekday_now      (m_weekday_now),
        .m_date_now         (m_date_now),
        .m_month_now        (m_month_now),
        .m_year_now         (m_year_now),
        .m_days_to_target   (m_days_to_target),
        .m_last_sunday_date (m_last_sunday_date)
    );

endmodule

FILE: rtl/ccls_ctrl.sv
// sequencer and handshake control for the calendar counter
module ccls_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  ccls_pkg::dp_sts_t sts,
    output ccls_pkg::dp_cmd_t cmd
);

    ccls_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign out_free = !m_valid_reg || m_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ccls_pkg::ST_IDLE: begin
                if (s_valid) state_next = ccls_pkg::ST_LEAP_CUR;
            end
            ccls_pkg::ST_LEAP_CUR: begin
                if (sts.act == ccls_pkg::ACT_TICK || sts.act == ccls_pkg::ACT_SET) begin
                    state_next = ccls_pkg::ST_EXEC;
                end else if (sts.act == ccls_pkg::ACT_QUERY && sts.target_ok) begin
                    state_next = ccls_pkg::ST_LEAP_NXT;
                end else begin
                    state_next = ccls_pkg::ST_DONE;
                end
            end
            ccls_pkg::ST_LEAP_NXT: state_next = ccls_pkg::ST_QINIT;
            ccls_pkg::ST_EXEC:     state_next = ccls_pkg::ST_DONE;
            ccls_pkg::ST_QINIT:    state_next = ccls_pkg::ST_QWALK;
            ccls_pkg::ST_QWALK: begin
                if (sts.walk_done) state_next = ccls_pkg::ST_SINIT;
            end
            ccls_pkg::ST_SINIT:    state_next = ccls_pkg::ST_SSTEP;
            ccls_pkg::ST_SSTEP: begin
                if (sts.step_done) state_next = ccls_pkg::ST_DONE;
            end
            ccls_pkg::ST_DONE: begin
                if (out_free) state_next = ccls_pkg::ST_IDLE;
            end
            default: state_next = ccls_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        unique case (state_reg)
            ccls_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ccls_pkg::ST_LEAP_CUR: cmd.leap_cur = 1'b1;
            ccls_pkg::ST_LEAP_NXT: cmd.leap_nxt = 1'b1;
            ccls_pkg::ST_EXEC:     cmd.exec     = 1'b1;
            ccls_pkg::ST_QINIT:    cmd.q_init   = 1'b1;
            ccls_pkg::ST_QWALK:    cmd.q_walk   = 1'b1;
            ccls_pkg::ST_SINIT:    cmd.s_init   = 1'b1;
            ccls_pkg::ST_SSTEP:    cmd.s_step   = 1'b1;
            ccls_pkg::ST_DONE:     cmd.res_load = out_free;
            default:               cmd          = '0;
        endcase
    end

    // result valid: set on load, cleared on transfer
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.res_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ccls_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/ccls_dp.sv
// calendar state, leap unit, month walk and last sunday stepping
module ccls_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ccls_pkg::dp_cmd_t                cmd,
    output ccls_pkg::dp_sts_t                sts,
    input  logic [ccls_pkg::ACT_W-1:0]       s_action,
    input  logic [ccls_pkg::WDAY_W-1:0]      s_set_weekday,
    input  logic [ccls_pkg::DATE_W-1:0]      s_set_day,
    input  logic [ccls_pkg::MONTH_W-1:0]     s_set_month,
    input  logic [ccls_pkg::YEAR_W-1:0]      s_set_year,
    input  logic [ccls_pkg::MONTH_W-1:0]     s_target_month,
    input  logic                             s_force_recalc,
    output logic [ccls_pkg::WDAY_W-1:0]      m_weekday_now,
    output logic [ccls_pkg::DATE_W-1:0]      m_date_now,
    output logic [ccls_pkg::MONTH_W-1:0]     m_month_now,
    output logic [ccls_pkg::YEAR_W-1:0]      m_year_now,
    output logic [ccls_pkg::DAYS_W-1:0]      m_days_to_target,
    output logic [ccls_pkg::DATE_W-1:0]      m_last_sunday_date
);

    // calendar state
    logic [ccls_pkg::WDAY_W-1:0]  weekday_reg, weekday_next;
    logic [ccls_pkg::DATE_W-1:0]  date_reg, date_next;
    logic [ccls_pkg::MONTH_W-1:0] month_reg, month_next;
    logic [ccls_pkg::YEAR_W-1:0]  year_reg, year_next;

    // captured item
    ccls_pkg::act_t               act_reg, act_next;
    logic [ccls_pkg::WDAY_W-1:0]  set_wd_reg, set_wd_next;
    logic [ccls_pkg::DATE_W-1:0]  set_day_reg, set_day_next;
    logic [ccls_pkg::MONTH_W-1:0] set_mon_reg, set_mon_next;
    logic [ccls_pkg::YEAR_W-1:0]  set_year_reg, set_year_next;
    logic [ccls_pkg::MONTH_W-1:0] tgt_reg, tgt_next;
    logic                         recalc_reg, recalc_next;

    // work registers
    logic                         leap_cur_reg, leap_cur_next;
    logic                         leap_nxt_reg, leap_nxt_next;
    logic [ccls_pkg::MONTH_W-1:0] mon_idx_reg, mon_idx_next;
    logic                         nysel_reg, nysel_next;
    logic                         cond_reg, cond_next;
    logic [ccls_pkg::DAYS_W-1:0]  acc_reg, acc_next;
    logic [ccls_pkg::DATE_W-1:0]  dt_reg, dt_next;
    logic [ccls_pkg::DATE_W-1:0]  len_reg, len_next;

    // result registers
    logic [ccls_pkg::WDAY_W-1:0]  out_wd_reg, out_wd_next;
    logic [ccls_pkg::DATE_W-1:0]  out_date_reg, out_date_next;
    logic [ccls_pkg::MONTH_W-1:0] out_mon_reg, out_mon_next;
    logic [ccls_pkg::YEAR_W-1:0]  out_year_reg, out_year_next;
    logic [ccls_pkg::DAYS_W-1:0]  out_days_reg, out_days_next;
    logic [ccls_pkg::DATE_W-1:0]  out_sun_reg, out_sun_next;

    // shared combinational terms
    logic [ccls_pkg::YEAR_W-1:0]  leap_in;
    logic                         leap_bit;
    logic [ccls_pkg::DATE_W-1:0]  cur_len;
    logic                         walk_leap;
    logic [ccls_pkg::DATE_W-1:0]  walk_len;
    logic [ccls_pkg::DATE_W-1:0]  tgt_len;
    logic [5:0]                   sun_guess;
    logic                         cond;
    logic [ccls_pkg::MONTH_W-1:0] mon_s;
    logic [ccls_pkg::DATE_W-1:0]  len_s;
    logic [ccls_pkg::DATE_W-1:0]  day_s;
    logic [3:0]                   first_wd;
    logic [5:0]                   dt0;

    // one leap unit, year chosen by the sequencer step and, for a load, the set year
    always_comb begin
        if (cmd.leap_nxt) begin
            leap_in = year_reg + ccls_pkg::YEAR_W'(1);
        end else if (act_reg == ccls_pkg::ACT_SET) begin
            leap_in = set_year_reg;
        end else begin
            leap_in = year_reg;
        end
        leap_bit = ccls_pkg::is_leap(leap_in);
    end

    assign cur_len   = ccls_pkg::month_len(month_reg, leap_cur_reg);
    assign walk_leap = nysel_reg ? leap_nxt_reg : leap_cur_reg;
    assign walk_len  = ccls_pkg::month_len(mon_idx_reg, walk_leap);
    assign tgt_len   = ccls_pkg::month_len(tgt_reg, walk_leap);
    // date of the coming sunday counted from today (today itself on a sunday), may lie past the month end
    assign sun_guess = 6'(date_reg) + 6'd7 - 6'(weekday_reg);
    assign cond      = (month_reg != tgt_reg) || (sun_guess > 6'(cur_len)) || recalc_reg;

    // sanitized load values
    always_comb begin
        mon_s = set_mon_reg;
        if (set_mon_reg == '0 || set_mon_reg > ccls_pkg::DECEMBER) mon_s = ccls_pkg::MONTH_W'(1);
        len_s = ccls_pkg::month_len(mon_s, leap_cur_reg);
        day_s = (set_day_reg == '0) ? ccls_pkg::DATE_W'(1) : set_day_reg;
        if (day_s > len_s) day_s = len_s;
    end

    // first sunday candidate in the target month
    always_comb begin
        first_wd = 4'(ccls_pkg::mod7(acc_reg)) + 4'(weekday_reg);
        if (first_wd > 4'd7) first_wd = first_wd - 4'd7;
        dt0 = sun_guess;
        if (dt0 > 6'(tgt_len)) dt0 = dt0 - 6'd7;
    end

    // status
    assign sts.act       = act_reg;
    assign sts.target_ok = (tgt_reg != '0) && (tgt_reg <= ccls_pkg::DECEMBER);
    assign sts.walk_done = (mon_idx_reg == tgt_reg);
    assign sts.step_done = (6'(dt_reg) + 6'd7) > 6'(len_reg);

    // next values
    always_comb begin
        weekday_next  = weekday_reg;
        date_next     = date_reg;
        month_next    = month_reg;
        year_next     = year_reg;
        act_next      = act_reg;
        set_wd_next   = set_wd_reg;
        set_day_next  = set_day_reg;
        set_mon_next  = set_mon_reg;
        set_year_next = set_year_reg;
        tgt_next      = tgt_reg;
        recalc_next   = recalc_reg;
        leap_cur_next = leap_cur_reg;
        leap_nxt_next = leap_nxt_reg;
        mon_idx_next  = mon_idx_reg;
        nysel_next    = nysel_reg;
        cond_next     = cond_reg;
        acc_next      = acc_reg;
        dt_next       = dt_reg;
        len_next      = len_reg;
        out_wd_next   = out_wd_reg;
        out_date_next = out_date_reg;
        out_mon_next  = out_mon_reg;
        out_year_next = out_year_reg;
        out_days_next = out_days_reg;
        out_sun_next  = out_sun_reg;

        // input transfer
        if (cmd.capture) begin
            act_next      = ccls_pkg::act_t'(s_action);
            set_wd_next   = s_set_weekday;
            set_day_next  = s_set_day;
            set_mon_next  = s_set_month;
            set_year_next = s_set_year;
            tgt_next      = s_target_month;
            recalc_next   = s_force_recalc;
            acc_next      = '0;
            dt_next       = '0;
        end

        if (cmd.leap_cur) leap_cur_next = leap_bit;
        if (cmd.leap_nxt) leap_nxt_next = leap_bit;

        // tick one day or load the calendar
        if (cmd.exec) begin
            if (act_reg == ccls_pkg::ACT_TICK) begin
                weekday_next = (weekday_reg == ccls_pkg::SUNDAY) ?
                               ccls_pkg::WDAY_W'(1) : weekday_reg + ccls_pkg::WDAY_W'(1);
                if (date_reg >= cur_len) begin
                    date_next = ccls_pkg::DATE_W'(1);
                    if (month_reg == ccls_pkg::DECEMBER) begin
                        month_next = ccls_pkg::MONTH_W'(1);
                        year_next  = year_reg + ccls_pkg::YEAR_W'(1);
                    end else begin
                        month_next = month_reg + ccls_pkg::MONTH_W'(1);
                    end
                end else begin
                    date_next = date_reg + ccls_pkg::DATE_W'(1);
                end
            end else begin
                weekday_next = (set_wd_reg == '0) ? ccls_pkg::WDAY_W'(1) : set_wd_reg;
                date_next    = day_s;
                month_next   = mon_s;
                year_next    = set_year_reg;
            end
        end

        // query setup: rest of this month plus one, or nothing when staying in it
        if (cmd.q_init) begin
            cond_next = cond;
            if (cond) begin
                acc_next     = ccls_pkg::DAYS_W'(cur_len - date_reg) + ccls_pkg::DAYS_W'(1);
                mon_idx_next = ccls_pkg::inc_month(month_reg);
                nysel_next   = (month_reg == ccls_pkg::DECEMBER);
            end else begin
                acc_next     = '0;
                mon_idx_next = tgt_reg;
                nysel_next   = 1'b0;
            end
        end

        // one whole month per cycle until the target month
        if (cmd.q_walk && !sts.walk_done) begin
            acc_next     = acc_reg + ccls_pkg::DAYS_W'(walk_len);
            nysel_next   = nysel_reg | (mon_idx_reg == ccls_pkg::DECEMBER);
            mon_idx_next = ccls_pkg::inc_month(mon_idx_reg);
        end

        // first sunday of the target month, or the coming one inside it
        if (cmd.s_init) begin
            len_next = tgt_len;
            if (cond_reg) begin
                dt_next = ccls_pkg::DATE_W'(4'd8 - first_wd);
            end else begin
                dt_next = ccls_pkg::DATE_W'(dt0);
            end
        end

        // one week per cycle up to the last sunday
        if (cmd.s_step && !sts.step_done) begin
            dt_next = dt_reg + ccls_pkg::DATE_W'(7);
        end

        // result register
        if (cmd.res_load) begin
            out_wd_next   = weekday_reg;
            out_date_next = date_reg;
            out_mon_next  = month_reg;
            out_year_next = year_reg;
            out_days_next = acc_reg;
            out_sun_next  = dt_reg;
        end
    end

    // calendar state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weekday_reg <= ccls_pkg::WDAY_RESET;
            date_reg    <= ccls_pkg::DATE_RESET;
            month_reg   <= ccls_pkg::MONTH_RESET;
            year_reg    <= ccls_pkg::YEAR_RESET;
        end else begin
            weekday_reg <= weekday_next;
            date_reg    <= date_next;
            month_reg   <= month_next;
            year_reg    <= year_next;
        end
    end

    // payload, work and result registers
    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        set_wd_reg   <= set_wd_next;
        set_day_reg  <= set_day_next;
        set_mon_reg  <= set_mon_next;
        set_year_reg <= set_year_next;
        tgt_reg      <= tgt_next;
        recalc_reg   <= recalc_next;
        leap_cur_reg <= leap_cur_next;
        leap_nxt_reg <= leap_nxt_next;
        mon_idx_reg  <= mon_idx_next;
        nysel_reg    <= nysel_next;
        cond_reg     <= cond_next;
        acc_reg      <= acc_next;
        dt_reg       <= dt_next;
        len_reg      <= len_next;
        out_wd_reg   <= out_wd_next;
        out_date_reg <= out_date_next;
        out_mon_reg  <= out_mon_next;
        out_year_reg <= out_year_next;
        out_days_reg <= out_days_next;
        out_sun_reg  <= out_sun_next;
    end

    assign m_weekday_now      = out_wd_reg;
    assign m_date_now         = out_date_reg;
    assign m_month_now        = out_mon_reg;
    assign m_year_now         = out_year_reg;
    assign m_days_to_target   = out_days_reg;
    assign m_last_sunday_date = out_sun_reg;

endmodule

FILE: rtl/ccls_checker.sv
// port-level checks for the calendar counter and their bind to the top level
module ccls_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_valid,
    input logic                             s_ready,
    input logic [ccls_pkg::ACT_W-1:0]       s_action,
    input logic [ccls_pkg::WDAY_W-1:0]      s_set_weekday,
    input logic [ccls_pkg::DATE_W-1:0]      s_set_day,
    input logic [ccls_pkg::MONTH_W-1:0]     s_set_month,
    input logic [ccls_pkg::YEAR_W-1:0]      s_set_year,
    input logic [ccls_pkg::MONTH_W-1:0]     s_target_month,
    input logic                             s_force_recalc,
    input logic                             m_valid,
    input logic                             m_ready,
    input logic [ccls_pkg::WDAY_W-1:0]      m_weekday_now,
    input logic [ccls_pkg::DATE_W-1:0]      m_date_now,
    input logic [ccls_pkg::MONTH_W-1:0]     m_month_now,
    input logic [ccls_pkg::YEAR_W-1:0]      m_year_now,
    input logic [ccls_pkg::DAYS_W-1:0]      m_days_to_target,
    input logic [ccls_pkg::DATE_W-1:0]      m_last_sunday_date
);

    // a stalled result holds its calendar fields
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_date_now) && $stable(m_month_now)
                                && $stable(m_year_now) && $stable(m_weekday_now))
        else $error("result changed while stalled");

    // reported weekday and month are always in range and the date is nonzero
    a_cal_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_weekday_now >= 3'd1 && m_weekday_now <= 3'd7 && m_date_now >= 5'd1
                    && m_month_now >= 4'd1 && m_month_now <= 4'd12)
        else $error("calendar out of range");

    // a last sunday lies in the final week of a month
    a_sun_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_sunday_date != 5'd0 |-> m_last_sunday_date >= 5'd22)
        else $error("last sunday too early");

    // nonzero day count comes only with a query answer
    a_days_sun: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_days_to_target != 9'd0 |-> m_last_sunday_date != 5'd0
                                              && m_days_to_target <= 9'd366)
        else $error("day count without sunday");

    // reset drops the result
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind calendar_counter_last_sunday_top ccls_checker u_ccls_checker (.*);

FILE: sim/tb_calendar_counter_last_sunday_top.sv
// testbench for the calendar counter: directed table, then random commands checked by a predictor
`timescale 1ns / 100ps

module tb_calendar_counter_last_sunday_top;

    localparam int RAND_ITEMS  = 850;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 250;
    localparam int DRAIN_WAIT  = 40;

    // one command as it goes over the input channel
    typedef struct packed {
        ccls_pkg::act_t               act;
        logic [ccls_pkg::WDAY_W-1:0]  wd;
        logic [ccls_pkg::DATE_W-1:0]  day;
        logic [ccls_pkg::MONTH_W-1:0] mon;
        logic [ccls_pkg::YEAR_W-1:0]  yr;
        logic [ccls_pkg::MONTH_W-1:0] tgt;
        logic                         rc;
    } cmd_t;

    // one result as it comes back on the result channel
    typedef struct packed {
        logic [ccls_pkg::WDAY_W-1:0]  wday;
        logic [ccls_pkg::DATE_W-1:0]  date;
        logic [ccls_pkg::MONTH_W-1:0] month;
        logic [ccls_pkg::YEAR_W-1:0]  year;
        logic [ccls_pkg::DAYS_W-1:0]  days;
        logic [ccls_pkg::DATE_W-1:0]  sun;
    } cal_res_t;

    // directed table row, with a typed-in result where it is obvious
    typedef struct packed {
        cmd_t     cmd;
        logic     typed;
        cal_res_t want;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    logic [ccls_pkg::ACT_W-1:0]   s_action;
    logic [ccls_pkg::WDAY_W-1:0]  s_set_weekday;
    logic [ccls_pkg::DATE_W-1:0]  s_set_day;
    logic [ccls_pkg::MONTH_W-1:0] s_set_month;
    logic [ccls_pkg::YEAR_W-1:0]  s_set_year;
    logic [ccls_pkg::MONTH_W-1:0] s_target_month;
    logic                         s_force_recalc;
    logic                         m_valid;
    logic                         m_ready;
    logic [ccls_pkg::WDAY_W-1:0]  m_weekday_now;
    logic [ccls_pkg::DATE_W-1:0]  m_date_now;
    logic [ccls_pkg::MONTH_W-1:0] m_month_now;
    logic [ccls_pkg::YEAR_W-1:0]  m_year_now;
    logic [ccls_pkg::DAYS_W-1:0]  m_days_to_target;
    logic [ccls_pkg::DATE_W-1:0]  m_last_sunday_date;

    // travels with the payload so the monitor knows which result to expect
    logic     row_typed;
    cal_res_t row_want;

    // predictor copy of the calendar
    int cal_wday;
    int cal_date;
    int cal_month;
    int cal_year;

    cal_res_t pending_cal_q[$];
    dir_row_t dir_rows[$];
    int       err_cnt = 0;
    int       cyc_cnt = 0;
    int       tx_idle = 32;
    bit       no_idle = 1'b0;
    bit       hold_req = 1'b0;
    bit       hold_done = 1'b0;

    calendar_counter_last_sunday_top dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_set_weekday      (s_set_weekday),
        .s_set_day          (s_set_day),
        .s_set_month        (s_set_month),
        .s_set_year         (s_set_year),
        .s_target_month     (s_target_month),
        .s_force_recalc     (s_force_recalc),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_weekday_now      (m_weekday_now),
        .m_date_now         (m_date_now),
        .m_month_now        (m_month_now),
        .m_year_now         (m_year_now),
        .m_days_to_target   (m_days_to_target),
        .m_last_sunday_date (m_last_sunday_date)
    );

    always #5 aclk = ~aclk;

    // gregorian leap rule
    function automatic bit leap_year(int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int month_days(int m, int y);
        if (m < 1 || m > 12) return 0;
        if (m == 2) return leap_year(y) ? 29 : 28;
        if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
        return 31;
    endfunction

    // apply one command to the predicted calendar and return the expected result
    function automatic cal_res_t advance_calendar(cmd_t c);
        cal_res_t r;
        int n, dt, fd, len, ty, ny, i, wd, d, m;
        n  = 0;
        dt = 0;
        case (c.act)
            ccls_pkg::ACT_TICK: begin
                cal_wday = (cal_wday >= 7) ? 1 : cal_wday + 1;
                cal_date = cal_date + 1;
                if (cal_date > month_days(cal_month, cal_year)) begin
                    cal_date = 1;
                    if (cal_month >= 12) begin
                        cal_month = 1;
                        cal_year  = (cal_year + 1) % 65536;
                    end else begin
                        cal_month = cal_month + 1;
                    end
                end
            end
            ccls_pkg::ACT_SET: begin
                m  = int'(c.mon);
                wd = int'(c.wd);
                d  = int'(c.day);
                if (m < 1 || m > 12) m = 1;
                if (wd < 1 || wd > 7) wd = 1;
                len = month_days(m, int'(c.yr));
                if (d < 1) d = 1;
                if (d > len) d = len;
                cal_wday  = wd;
                cal_date  = d;
                cal_month = m;
                cal_year  = int'(c.yr);
            end
            ccls_pkg::ACT_QUERY: begin
                if (c.tgt >= 1 && c.tgt <= 12) begin
                    ny = (cal_year + 1) % 65536;
                    ty = cal_year;
                    // count days to the target month unless in it with a sunday due, not forced
                    if (cal_month != int'(c.tgt) || c.rc ||
                        cal_date + 7 - cal_wday > month_days(cal_month, cal_year)) begin
                        n = month_days(cal_month, cal_year) - cal_date;
                        if (cal_month < int'(c.tgt)) begin
                            for (i = cal_month + 1; i < int'(c.tgt); i++)
                                n += month_days(i, cal_year);
                        end else begin
                            for (i = cal_month + 1; i <= 12; i++)
                                n += month_days(i, cal_year);
                            for (i = 1; i < int'(c.tgt); i++)
                                n += month_days(i, ny);
                            ty = ny;
                        end
                        n += 1;
                    end
                    len = month_days(int'(c.tgt), ty);
                    // first sunday, then walk weeks to the last one
                    if (n != 0) begin
                        fd = (n % 7) + cal_wday;
                        if (fd > 7) fd -= 7;
                        dt = 8 - fd;
                    end else begin
                        dt = cal_date + 7 - cal_wday;
                        if (dt > len) dt -= 7;
                    end
                    while (dt <= len) dt += 7;
                    dt -= 7;
                    if (dt < 0) dt = 0;
                end
            end
            default: ;
        endcase
        r.wday  = ccls_pkg::WDAY_W'(cal_wday);
        r.date  = ccls_pkg::DATE_W'(cal_date);
        r.month = ccls_pkg::MONTH_W'(cal_month);
        r.year  = ccls_pkg::YEAR_W'(cal_year);
        r.days  = ccls_pkg::DAYS_W'(n);
        r.sun   = ccls_pkg::DATE_W'(dt);
        return r;
    endfunction

    function automatic cmd_t mk_cmd(ccls_pkg::act_t a, int wd, int day, int mon, int yr,
                                    int tgt, int rc);
        cmd_t c;
        c.act = a;
        c.wd  = ccls_pkg::WDAY_W'(wd);
        c.day = ccls_pkg::DATE_W'(day);
        c.mon = ccls_pkg::MONTH_W'(mon);
        c.yr  = ccls_pkg::YEAR_W'(yr);
        c.tgt = ccls_pkg::MONTH_W'(tgt);
        c.rc  = 1'(rc);
        return c;
    endfunction

    // calendar-only result, query fields zero
    function automatic cal_res_t mk_res(int wd, int d, int m, int y);
        cal_res_t r;
        r.wday  = ccls_pkg::WDAY_W'(wd);
        r.date  = ccls_pkg::DATE_W'(d);
        r.month = ccls_pkg::MONTH_W'(m);
        r.year  = ccls_pkg::YEAR_W'(y);
        r.days  = '0;
        r.sun   = '0;
        return r;
    endfunction

    function automatic void dir_add(cmd_t c, bit typed, cal_res_t want);
        dir_row_t row;
        row.cmd   = c;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    // random command: mostly sane sets and in-range targets, some noise
    function automatic cmd_t rand_cmd();
        int  years[10] = '{1900, 2000, 2100, 2400, 2023, 2024, 0, 65532, 65535, 4};
        cmd_t c;
        int   r;
        c.wd  = ccls_pkg::WDAY_W'($urandom);
        c.day = ccls_pkg::DATE_W'($urandom);
        c.mon = ccls_pkg::MONTH_W'($urandom);
        c.yr  = ccls_pkg::YEAR_W'($urandom);
        c.tgt = ccls_pkg::MONTH_W'($urandom_range(3, 12));
        c.rc  = 1'($urandom);
        r = $urandom_range(99);
        if (r < 35) c.act = ccls_pkg::ACT_TICK;
        else if (r < 55) c.act = ccls_pkg::ACT_SET;
        else if (r < 95) c.act = ccls_pkg::ACT_QUERY;
        else c.act = ccls_pkg::ACT_NONE;
        if (c.act == ccls_pkg::ACT_SET && $urandom_range(9) < 8) begin
            c.wd  = ccls_pkg::WDAY_W'($urandom_range(1, 7));
            c.mon = ccls_pkg::MONTH_W'($urandom_range(1, 12));
            if ($urandom_range(1)) c.day = ccls_pkg::DATE_W'($urandom_range(25, 31));
            if ($urandom_range(1)) c.yr = ccls_pkg::YEAR_W'(years[$urandom_range(9)]);
        end
        if (c.act == ccls_pkg::ACT_QUERY && $urandom_range(9) == 0)
            c.tgt = ccls_pkg::MONTH_W'($urandom);
        return c;
    endfunction

    task automatic flag_error(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // offer one command and wait for its transfer
    task automatic offer(cmd_t c, bit typed, cal_res_t want);
        while ($urandom_range(99) < tx_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= c.act;
        s_set_weekday  <= c.wd;
        s_set_day      <= c.day;
        s_set_month    <= c.mon;
        s_set_year     <= c.yr;
        s_target_month <= c.tgt;
        s_force_recalc <= c.rc;
        row_typed      <= typed;
        row_want       <= want;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // predict on input transfers, check on result transfers
    always @(posedge aclk) begin
        cmd_t     c;
        cal_res_t p;
        cal_res_t w;
        cal_res_t got;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                c.act = ccls_pkg::act_t'(s_action);
                c.wd  = s_set_weekday;
                c.day = s_set_day;
                c.mon = s_set_month;
                c.yr  = s_set_year;
                c.tgt = s_target_month;
                c.rc  = s_force_recalc;
                p = advance_calendar(c);
                pending_cal_q.push_back(row_typed ? row_want : p);
            end
            if (m_valid && m_ready) begin
                got.wday  = m_weekday_now;
                got.date  = m_date_now;
                got.month = m_month_now;
                got.year  = m_year_now;
                got.days  = m_days_to_target;
                got.sun   = m_last_sunday_date;
                if (pending_cal_q.size() == 0) begin
                    flag_error("result transfer with nothing pending");
                end else begin
                    w = pending_cal_q.pop_front();
                    if (got !== w)
                        flag_error({$sformatf("got wd %0d %0d/%0d/%0d days %0d sun %0d",
                                              got.wday, got.date, got.month, got.year,
                                              got.days, got.sun),
                                    $sformatf(", want wd %0d %0d/%0d/%0d days %0d sun %0d",
                                              w.wday, w.date, w.month, w.year,
                                              w.days, w.sun)});
                end
            end
        end
    end

    // receiver: random backpressure, one long hold-off on request
    initial begin
        int k;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                for (k = 0; k < HOLD_CYCLES; k++) @(posedge aclk);
                hold_done = 1'b1;
            end else if (no_idle) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 32);
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cyc_cnt++;
        if (cyc_cnt >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // stimulus
    initial begin
        cal_res_t none;
        none = '0;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_action       <= ccls_pkg::ACT_TICK;
        s_set_weekday  <= '0;
        s_set_day      <= '0;
        s_set_month    <= '0;
        s_set_year     <= '0;
        s_target_month <= '0;
        s_force_recalc <= 1'b0;
        row_typed      <= 1'b0;
        row_want       <= '0;
        cal_wday  = 1;
        cal_date  = 1;
        cal_month = 1;
        cal_year  = 2000;

        // directed: reset value, sanitizing, leap rule, year wrap, bad targets
        dir_add(mk_cmd(ccls_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0), 1, mk_res(2, 2, 1, 2000));
        dir_add(mk_cmd(ccls_pkg::ACT_SET, 0, 0, 0, 0, 0, 0), 1, mk_res(1, 1, 1, 0));
        dir_add(mk_cmd(ccls_pkg::ACT_SET, 7, 31, 2, 2000, 0, 0), 1, mk_res(7, 29, 2, 2000));
        dir_add(mk_cmd(ccls_pkg::ACT_SET, 7, 31, 2, 1900, 0, 0), 1, mk_res(7, 28, 2, 1900));
        dir_add(mk_cmd(ccls_pkg::ACT_SET, 3, 31, 2, 2100, 0, 0), 1, mk_res(3, 28, 2, 2100));
        dir_add(mk_cmd(ccls_pkg::ACT_SET, 5, 30, 2, 2024, 0, 0), 1, mk_res(5, 29, 2, 2024));
        dir_add(mk_cmd(ccls_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0), 1, mk_res(6, 1, 3, 2024));
        dir_add(mk_cmd(ccls_pkg::ACT_SET, 6, 31, 12, 65535, 0, 0), 1,
                mk_res(6, 31, 12, 65535));
        dir_add(mk_cmd(ccls_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0), 1, mk_res(7, 1, 1, 0));
        dir_add(mk_cmd(ccls_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0), 1, mk_res(1, 2, 1, 0));
        dir_add(mk_cmd(ccls_pkg::ACT_SET, 0, 15, 15, 'hA5A5, 0, 0), 1,
                mk_res(1, 15, 1, 'hA5A5));
        dir_add(mk_cmd(ccls_pkg::ACT_SET, 4, 31, 13, 'h5A5A, 0, 0), 1,
                mk_res(4, 31, 1, 'h5A5A));
        dir_add(mk_cmd(ccls_pkg::ACT_QUERY, 0, 0, 0, 0, 0, 0), 1, mk_res(4, 31, 1, 'h5A5A));
        dir_add(mk_cmd(ccls_pkg::ACT_QUERY, 0, 0, 0, 0, 15, 1), 1, mk_res(4, 31, 1, 'h5A5A));
        dir_add(mk_cmd(ccls_pkg::ACT_NONE, 7, 31, 15, 'hFFFF, 15, 1), 1,
                mk_res(4, 31, 1, 'h5A5A));
        dir_add(mk_cmd(ccls_pkg::ACT_QUERY, 0, 0, 0, 0, 13, 0), 1, mk_res(4, 31, 1, 'h5A5A));
        // queries checked by the predictor: inside the target, forced, wrapping
        dir_add(mk_cmd(ccls_pkg::ACT_SET, 5, 1, 3, 2024, 0, 0), 0, none);
        dir_add(mk_cmd(ccls_pkg::ACT_QUERY, 0, 0, 0, 0, 3, 0), 0, none);
        dir_add(mk_cmd(ccls_pkg::ACT_QUERY, 0, 0, 0, 0, 3, 1), 0, none);
        dir_add(mk_cmd(ccls_pkg::ACT_SET, 4, 28, 3, 2024, 0, 0), 0, none);
        dir_add(mk_cmd(ccls_pkg::ACT_QUERY, 0, 0, 0, 0, 3, 0), 0, none);
        dir_add(mk_cmd(ccls_pkg::ACT_SET, 1, 30, 3, 2024, 0, 0), 0, none);
        dir_add(mk_cmd(ccls_pkg::ACT_QUERY, 0, 0, 0, 0, 3, 0), 0, none);
        dir_add(mk_cmd(ccls_pkg::ACT_SET, 7, 31, 12, 2023, 0, 0), 0, none);
        dir_add(mk_cmd(ccls_pkg::ACT_QUERY, 0, 0, 0, 0, 12, 0), 0, none);
        dir_add(mk_cmd(ccls_pkg::ACT_QUERY, 0, 0, 0, 0, 3, 0), 0, none);
        dir_add(mk_cmd(ccls_pkg::ACT_SET, 6, 31, 12, 65535, 0, 0), 0, none);
        dir_add(mk_cmd(ccls_pkg::ACT_QUERY, 0, 0, 0, 0, 2, 1), 0, none);
        dir_add(mk_cmd(ccls_pkg::ACT_QUERY, 0, 0, 0, 0, 12, 1), 0, none);
        dir_add(mk_cmd(ccls_pkg::ACT_SET, 7, 1, 1, 2023, 0, 0), 0, none);
        dir_add(mk_cmd(ccls_pkg::ACT_QUERY, 0, 0, 0, 0, 1, 1), 0, none);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < dir_rows.size(); i++)
            offer(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

        // random commands with pressure phases
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == 200) begin
                // receiver stops while the sender keeps offering
                hold_req = 1'b1;
                tx_idle  = 0;
            end
            if (i == 300) tx_idle = 32;
            if (i == 400) begin
                // sender pause until every pending result is back
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending_cal_q.size() != 0) @(posedge aclk);
            end
            if (i == 500) begin
                tx_idle = 0;
                no_idle = 1'b1;
            end
            if (i == 650) begin
                tx_idle = 32;
                no_idle = 1'b0;
            end
            offer(rand_cmd(), 1'b0, none);
        end
        s_valid <= 1'b0;

        // drain
        while (pending_cal_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_cnt == 0 && pending_cal_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
